[design/assert_macros.svh]
// Assertion macros shared by the RTL of the point list.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/upol_pkg.sv]
// Shared constants of the unique point ordered list: field widths,
// command and status codes. No dependencies.
`timescale 1ns / 1ps

package upol_pkg;

  localparam int unsigned CAPACITY_DEF = 32;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ECOUNT_W = 6;
  localparam int unsigned POINT_W  = 2 * COORD_W;

  localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LIST     = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

endpackage

[design/upol_mem.sv]
// Point storage of the list: one write port, one read port with registered data.
// Depends on upol_pkg for default widths.
`timescale 1ns / 1ps

module upol_mem #(
  parameter int unsigned DEPTH = upol_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(upol_pkg::CAPACITY_DEF),
  parameter int unsigned DW    = upol_pkg::POINT_W
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/unique_point_ordered_list.sv]
// Ordered list of unique (x,y) points: command sequencer around the point memory.
// Depends on upol_pkg, upol_mem and assert_macros.svh.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; results come out one
// word per cycle on out_valid and must be taken as they appear. Every defined
// command but a list of a non-empty list gives one word with out_last set; a list
// gives one word per entry in order, and the unused codes give none. The single
// read port of the point memory is walked one entry per cycle: an immediate
// decision is made in the idle state; append, insert, remove and contains search
// the list, delete and remove shift the entries above down one place, and insert
// shifts the entries up from the tail and writes the point. The memory needs
// no clearing after reset, since only entries below the count are ever read.
module unique_point_ordered_list #(
  parameter int unsigned CAPACITY = upol_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [upol_pkg::CMD_W-1:0]     in_command,
  input  logic [upol_pkg::COORD_W-1:0]   in_x_coord,
  input  logic [upol_pkg::COORD_W-1:0]   in_y_coord,
  input  logic [upol_pkg::POS_W-1:0]     in_position,
  output logic                           out_valid,
  output logic [upol_pkg::STATUS_W-1:0]  out_status,
  output logic                           out_found,
  output logic [upol_pkg::ECOUNT_W-1:0]  out_entry_count,
  output logic [upol_pkg::COORD_W-1:0]   out_out_x,
  output logic [upol_pkg::COORD_W-1:0]   out_out_y,
  output logic                           out_last
);

  import upol_pkg::*;

`include "assert_macros.svh"

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned MW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SEARCH    = 3'd1;
  localparam logic [2:0] S_INS_SHIFT = 3'd2;
  localparam logic [2:0] S_INS_WRITE = 3'd3;
  localparam logic [2:0] S_DEL_SHIFT = 3'd4;
  localparam logic [2:0] S_LIST      = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                pend_r, pend_nxt;
  logic [CW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [COORD_W-1:0]  x_r, x_nxt;
  logic [COORD_W-1:0]  y_r, y_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_found_r, out_found_nxt;
  logic [ECOUNT_W-1:0] out_entry_count_r, out_entry_count_nxt;
  logic [COORD_W-1:0]  out_x_r, out_x_nxt;
  logic [COORD_W-1:0]  out_y_r, out_y_nxt;
  logic                out_last_r, out_last_nxt;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [POINT_W-1:0]  wr_data;
  logic [POINT_W-1:0]  rd_data;

  logic                emit;
  logic [STATUS_W-1:0] e_status;
  logic                e_found;
  logic [COORD_W-1:0]  e_x;
  logic [COORD_W-1:0]  e_y;
  logic                e_last;

  logic                hit;
  logic                last_cmp;
  logic                empty;
  logic                pos_ok;
  logic [CW-1:0]       count_dec;
  logic [CW-1:0]       cmp_up;
  logic [CW-1:0]       cmp_dn;

  upol_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (POINT_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign count_dec = count_r - ONE_C;
  assign cmp_up    = cmp_idx_r + ONE_C;
  assign cmp_dn    = cmp_idx_r - ONE_C;
  assign hit       = pend_r && (rd_data == {x_r, y_r});
  assign last_cmp  = (cmp_idx_r == count_dec);
  assign empty     = (count_r == '0);
  assign pos_ok    = (MW'(in_position) < MW'(count_r));

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    pend_nxt    = 1'b0;
    rd_idx_nxt  = rd_idx_r;
    cmp_idx_nxt = cmp_idx_r;
    cmd_nxt     = cmd_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    pos_nxt     = pos_r;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = {x_r, y_r};
    emit        = 1'b0;
    e_status    = ST_OK;
    e_found     = 1'b0;
    e_x         = '0;
    e_y         = '0;
    e_last      = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_command;
          x_nxt      = in_x_coord;
          y_nxt      = in_y_coord;
          pos_nxt    = CW'(in_position);
          rd_idx_nxt = '0;
          case (in_command)
            CMD_APPEND: begin
              if (empty) begin
                wr_en     = 1'b1;
                wr_data   = {in_x_coord, in_y_coord};
                count_nxt = ONE_C;
                emit      = 1'b1;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            CMD_INSERT: begin
              if (!pos_ok) begin
                emit     = 1'b1;
                e_status = ST_BADPOS;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            CMD_DELETE: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else if (!pos_ok) begin
                emit     = 1'b1;
                e_status = ST_BADPOS;
              end else if (CW'(in_position) == count_dec) begin
                // The last entry goes without any shifting.
                count_nxt = count_dec;
                emit      = 1'b1;
              end else begin
                rd_idx_nxt = CW'(in_position) + ONE_C;
                state_nxt  = S_DEL_SHIFT;
              end
            end
            CMD_REMOVE: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            CMD_CONTAINS: begin
              if (empty) begin
                emit = 1'b1;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            CMD_LIST: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                state_nxt = S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SEARCH: begin
        // One read is issued per cycle; its data is compared in the next cycle.
        pend_nxt    = 1'b1;
        cmp_idx_nxt = rd_idx_r;
        rd_idx_nxt  = rd_idx_r + ONE_C;
        if (pend_r && (hit || last_cmp)) begin
          pend_nxt  = 1'b0;
          state_nxt = S_IDLE;
          case (cmd_r)
            CMD_APPEND: begin
              emit = 1'b1;
              if (hit) begin
                e_status = ST_DUP;
              end else if (count_r == CAP_C) begin
                e_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = count_r[AW-1:0];
                count_nxt = count_r + ONE_C;
              end
            end
            CMD_INSERT: begin
              if (hit) begin
                emit     = 1'b1;
                e_status = ST_DUP;
              end else if (count_r == CAP_C) begin
                emit     = 1'b1;
                e_status = ST_FULL;
              end else begin
                rd_idx_nxt = count_dec;
                state_nxt  = S_INS_SHIFT;
              end
            end
            CMD_REMOVE: begin
              if (!hit) begin
                emit     = 1'b1;
                e_status = ST_NOTFOUND;
              end else if (last_cmp) begin
                count_nxt = count_dec;
                emit      = 1'b1;
              end else begin
                rd_idx_nxt = cmp_up;
                state_nxt  = S_DEL_SHIFT;
              end
            end
            CMD_CONTAINS: begin
              emit    = 1'b1;
              e_found = hit;
            end
            default: begin
            end
          endcase
        end
      end

      S_INS_SHIFT: begin
        // Walk down from the tail, moving each entry one place up.
        pend_nxt    = 1'b1;
        cmp_idx_nxt = rd_idx_r;
        rd_idx_nxt  = rd_idx_r - ONE_C;
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = cmp_up[AW-1:0];
          wr_data = rd_data;
          if (cmp_idx_r == pos_r) begin
            pend_nxt  = 1'b0;
            state_nxt = S_INS_WRITE;
          end
        end
      end

      S_INS_WRITE: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r[AW-1:0];
        count_nxt = count_r + ONE_C;
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end

      S_DEL_SHIFT: begin
        // Walk up toward the tail, moving each entry one place down.
        pend_nxt    = 1'b1;
        cmp_idx_nxt = rd_idx_r;
        rd_idx_nxt  = rd_idx_r + ONE_C;
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = cmp_dn[AW-1:0];
          wr_data = rd_data;
          if (last_cmp) begin
            pend_nxt  = 1'b0;
            count_nxt = count_dec;
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end

      S_LIST: begin
        pend_nxt    = 1'b1;
        cmp_idx_nxt = rd_idx_r;
        rd_idx_nxt  = rd_idx_r + ONE_C;
        if (pend_r) begin
          emit   = 1'b1;
          e_x    = rd_data[POINT_W-1:COORD_W];
          e_y    = rd_data[COORD_W-1:0];
          e_last = last_cmp;
          if (last_cmp) begin
            pend_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt       = emit;
    out_status_nxt      = out_status_r;
    out_found_nxt       = out_found_r;
    out_entry_count_nxt = out_entry_count_r;
    out_x_nxt           = out_x_r;
    out_y_nxt           = out_y_r;
    out_last_nxt        = out_last_r;
    if (emit) begin
      out_status_nxt      = e_status;
      out_found_nxt       = e_found;
      out_entry_count_nxt = ECOUNT_W'(count_nxt);
      out_x_nxt           = e_x;
      out_y_nxt           = e_y;
      out_last_nxt        = e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r          <= rd_idx_nxt;
    cmp_idx_r         <= cmp_idx_nxt;
    cmd_r             <= cmd_nxt;
    x_r               <= x_nxt;
    y_r               <= y_nxt;
    pos_r             <= pos_nxt;
    out_status_r      <= out_status_nxt;
    out_found_r       <= out_found_nxt;
    out_entry_count_r <= out_entry_count_nxt;
    out_x_r           <= out_x_nxt;
    out_y_r           <= out_y_nxt;
    out_last_r        <= out_last_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_entry_count = out_entry_count_r;
  assign out_out_x       = out_x_r;
  assign out_out_y       = out_y_r;
  assign out_last        = out_last_r;

  // An insert shift writes one place past the current tail before the count grows.
  `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CAP_C, "entry count above capacity")
  `ASSERT_IMPL(a_last_idle, clk, rst_n, out_valid_r && out_last_r, state_r == S_IDLE,
               "final word shown while a command is still running")
  `ASSERT_NEXT(a_list_burst, clk, rst_n, out_valid_r && !out_last_r, out_valid_r,
               "gap inside a list burst")
  `ASSERT_IMPL(a_wr_range, clk, rst_n, wr_en, CW'(wr_addr) <= count_r,
               "write beyond the end of the list")

endmodule

[tb/point_list_checker.sv]
// Checker for the unique point ordered list: watches the command and result channels,
// keeps its own copy of the list, predicts every result word and compares field by field.
// Depends on upol_pkg.
`timescale 1ns / 1ps

module point_list_checker #(
  parameter int unsigned CAPACITY = upol_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [upol_pkg::CMD_W-1:0]     in_command,
  input  logic [upol_pkg::COORD_W-1:0]   in_x_coord,
  input  logic [upol_pkg::COORD_W-1:0]   in_y_coord,
  input  logic [upol_pkg::POS_W-1:0]     in_position,
  input  logic                           out_valid,
  input  logic [upol_pkg::STATUS_W-1:0]  out_status,
  input  logic                           out_found,
  input  logic [upol_pkg::ECOUNT_W-1:0]  out_entry_count,
  input  logic [upol_pkg::COORD_W-1:0]   out_out_x,
  input  logic [upol_pkg::COORD_W-1:0]   out_out_y,
  input  logic                           out_last,
  output int                             mismatches,
  output int                             words_due
);
  import upol_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [ECOUNT_W-1:0] entry_count;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic                last;
  } result_word_t;

  logic [COORD_W-1:0] list_x [CAPACITY];
  logic [COORD_W-1:0] list_y [CAPACITY];
  int                 list_len = 0;
  result_word_t       due_q[$];
  int                 mismatch_total = 0;

  task automatic report_mismatch(input string what);
    mismatch_total++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Index of the matching entry, or the list length when the point is absent.
  // Equality is on raw bits, so +0 and -0 are different points.
  function automatic int locate(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    for (int i = 0; i < list_len; i++)
      if (list_x[i] == x && list_y[i] == y) return i;
    return list_len;
  endfunction

  task automatic insert_at(input int pos, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y);
    for (int i = list_len; i > pos; i--) begin
      list_x[i] = list_x[i-1];
      list_y[i] = list_y[i-1];
    end
    list_x[pos] = x;
    list_y[pos] = y;
    list_len++;
  endtask

  task automatic delete_at(input int pos);
    for (int i = pos; i + 1 < list_len; i++) begin
      list_x[i] = list_x[i+1];
      list_y[i] = list_y[i+1];
    end
    list_len--;
  endtask

  task automatic push_word(input logic [STATUS_W-1:0] st, input logic fnd,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic lst);
    result_word_t w;
    w.status      = st;
    w.found       = fnd;
    w.entry_count = list_len[ECOUNT_W-1:0];
    w.x           = x;
    w.y           = y;
    w.last        = lst;
    due_q.push_back(w);
  endtask

  // Applies one accepted command to the list copy and queues the words it causes.
  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y, input logic [POS_W-1:0] pos);
    int                  hit;
    logic [STATUS_W-1:0] st;
    logic                fnd;
    bit                  one_word;
    hit      = locate(x, y);
    st       = ST_OK;
    fnd      = 1'b0;
    one_word = 1'b1;
    case (cmd)
      CMD_APPEND: begin
        if (hit < list_len) st = ST_DUP;
        else if (list_len >= CAPACITY) st = ST_FULL;
        else insert_at(list_len, x, y);
      end
      CMD_INSERT: begin
        if (pos >= list_len) st = ST_BADPOS;
        else if (hit < list_len) st = ST_DUP;
        else if (list_len >= CAPACITY) st = ST_FULL;
        else insert_at(pos, x, y);
      end
      CMD_DELETE: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (pos >= list_len) st = ST_BADPOS;
        else delete_at(pos);
      end
      CMD_REMOVE: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (hit < list_len) delete_at(hit);
        else st = ST_NOTFOUND;
      end
      CMD_CONTAINS: begin
        fnd = (hit < list_len);
      end
      CMD_LIST: begin
        one_word = 1'b0;
        if (list_len == 0) push_word(ST_EMPTY, 1'b0, '0, '0, 1'b1);
        else
          for (int i = 0; i < list_len; i++)
            push_word(ST_OK, 1'b0, list_x[i], list_y[i], i + 1 == list_len);
      end
      default: begin
        // The two unused codes are dropped without a word.
        one_word = 1'b0;
      end
    endcase
    if (one_word) push_word(st, fnd, '0, '0, 1'b1);
  endtask

  always @(posedge clk) begin
    result_word_t want;
    if (!rst_n) begin
      list_len = 0;
      due_q.delete();
    end else begin
      if (out_valid) begin
        if (due_q.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = due_q.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", out_found, want.found));
          if (out_entry_count !== want.entry_count)
            report_mismatch($sformatf("entry count %0d, expected %0d",
                                      out_entry_count, want.entry_count));
          if (out_out_x !== want.x)
            report_mismatch($sformatf("x %h, expected %h", out_out_x, want.x));
          if (out_out_y !== want.y)
            report_mismatch($sformatf("y %h, expected %h", out_out_y, want.y));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", out_last, want.last));
        end
      end
      if (start && !busy) apply_command(in_command, in_x_coord, in_y_coord, in_position);
    end
    mismatches <= mismatch_total;
    words_due  <= due_q.size();
  end

endmodule

[tb/tb.sv]
// Top of the point list testbench: clock, reset, command stimulus and the verdict.
// Depends on upol_pkg, unique_point_ordered_list and point_list_checker.
`timescale 1ns / 1ps

module tb;
  import upol_pkg::*;

  localparam int POOL_SIZE = 40;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    in_command;
  logic [COORD_W-1:0]  in_x_coord;
  logic [COORD_W-1:0]  in_y_coord;
  logic [POS_W-1:0]    in_position;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic                out_found;
  logic [ECOUNT_W-1:0] out_entry_count;
  logic [COORD_W-1:0]  out_out_x;
  logic [COORD_W-1:0]  out_out_y;
  logic                out_last;
  int                  mismatches;
  int                  words_due;

  // Points drawn from a small pool so that duplicates, hits and a full list are common.
  logic [COORD_W-1:0]  pool_x [POOL_SIZE];
  logic [COORD_W-1:0]  pool_y [POOL_SIZE];
  int                  sent;
  bit                  no_gaps;

  unique_point_ordered_list dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_x_coord(in_x_coord), .in_y_coord(in_y_coord),
    .in_position(in_position), .out_valid(out_valid), .out_status(out_status),
    .out_found(out_found), .out_entry_count(out_entry_count), .out_out_x(out_out_x),
    .out_out_y(out_out_y), .out_last(out_last)
  );

  point_list_checker list_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_x_coord(in_x_coord), .in_y_coord(in_y_coord),
    .in_position(in_position), .out_valid(out_valid), .out_status(out_status),
    .out_found(out_found), .out_entry_count(out_entry_count), .out_out_x(out_out_x),
    .out_out_y(out_out_y), .out_last(out_last), .mismatches(mismatches),
    .words_due(words_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Holds start high across back-to-back commands, so it is only lowered for a real gap.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic [POS_W-1:0] pos);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_command  <= cmd;
    in_x_coord  <= x;
    in_y_coord  <= y;
    in_position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd <= CMD_LIST) sent++;
  endtask

  task automatic send_point(input logic [CMD_W-1:0] cmd, input int idx,
                            input logic [POS_W-1:0] pos);
    send_command(cmd, pool_x[idx], pool_y[idx], pos);
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'($urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 5));
  endfunction

  initial begin
    int base;
    int n;
    int r;
    start       = 1'b0;
    rst_n       = 1'b0;
    in_command  = '0;
    in_x_coord  = '0;
    in_y_coord  = '0;
    in_position = '0;
    sent        = 0;
    no_gaps     = 1'b0;
    pool_x[0] = 32'h0000_0000; pool_y[0] = 32'h0000_0000;
    pool_x[1] = 32'h8000_0000; pool_y[1] = 32'h0000_0000;
    pool_x[2] = 32'h0000_0000; pool_y[2] = 32'h8000_0000;
    pool_x[3] = 32'hFFFF_FFFF; pool_y[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) begin
      pool_x[i] = $urandom;
      pool_y[i] = $urandom;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every command on an empty list, then signed zeros, duplicates and
    // bad positions on a short list, the unused codes, and emptying by deletion and removal.
    send_command(CMD_LIST, '0, '0, '0);
    send_command(CMD_DELETE, '0, '0, '0);
    send_point(CMD_REMOVE, 0, '0);
    send_point(CMD_INSERT, 0, '0);
    send_point(CMD_CONTAINS, 0, '0);
    send_point(CMD_APPEND, 0, '0);
    send_point(CMD_APPEND, 1, '0);
    send_point(CMD_APPEND, 0, '0);
    send_point(CMD_CONTAINS, 1, '0);
    send_point(CMD_CONTAINS, 2, '0);
    send_point(CMD_INSERT, 3, 5'd0);
    send_point(CMD_INSERT, 2, 5'd3);
    send_point(CMD_INSERT, 0, 5'd1);
    send_command(CMD_LIST, '1, '1, '1);
    send_command(CMD_DELETE, '0, '0, 5'd31);
    send_point(CMD_REMOVE, 2, '0);
    send_point(3'd6, 0, '0);
    send_point(3'd7, 3, 5'd31);
    send_command(CMD_DELETE, '0, '0, 5'd0);
    send_point(CMD_REMOVE, 0, '0);
    send_command(CMD_DELETE, '0, '0, 5'd0);
    send_command(CMD_LIST, '0, '0, '0);

    while (sent < 410) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: begin
          // Fill toward a full list, then probe it with inserts and a listing.
          base = $urandom_range(0, POOL_SIZE - 1);
          n    = $urandom_range(30, 40);
          for (int k = 0; k < n; k++)
            if ($urandom_range(0, 4) == 0)
              send_point(CMD_INSERT, (base + k) % POOL_SIZE, rand_pos());
            else
              send_point(CMD_APPEND, (base + k) % POOL_SIZE, rand_pos());
          send_command(CMD_LIST, $urandom, $urandom, rand_pos());
        end
        1: begin
          for (int k = 0; k < 20; k++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 6) == 0) begin
              send_command(r < 25 ? CMD_APPEND : r < 40 ? CMD_INSERT : r < 55 ? CMD_DELETE :
                           r < 70 ? CMD_REMOVE : r < 85 ? CMD_CONTAINS : CMD_LIST,
                           $urandom, $urandom, rand_pos());
            end else begin
              send_point(r < 25 ? CMD_APPEND : r < 40 ? CMD_INSERT : r < 55 ? CMD_DELETE :
                         r < 70 ? CMD_REMOVE : r < 85 ? CMD_CONTAINS :
                         r < 95 ? CMD_LIST : 3'($urandom_range(6, 7)),
                         $urandom_range(0, POOL_SIZE - 1), rand_pos());
            end
          end
        end
        2: begin
          n = $urandom_range(10, 35);
          for (int k = 0; k < n; k++)
            if ($urandom_range(0, 1) == 0)
              send_command(CMD_DELETE, $urandom, $urandom, rand_pos());
            else
              send_point(CMD_REMOVE, $urandom_range(0, POOL_SIZE - 1), rand_pos());
          send_command(CMD_LIST, $urandom, $urandom, rand_pos());
        end
        default: begin
          for (int k = 0; k < 10; k++)
            send_command(3'($urandom_range(0, 7)), $urandom, $urandom, 5'($urandom));
        end
      endcase
    end

    start <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && words_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
